@@ rtl/core/ths_pkg.sv @@
// Shared types and constants for the terrain height sampler.
// Beat payloads, pipeline structs, operation and register codes.
// No dependencies.
`default_nettype none

package ths_pkg;

  // Fixed field widths
  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned CELL_W   = 9;   // grid cell index inside the pipe
  localparam int unsigned PROD_W   = 17;  // 9-bit weight times 8-bit height

  // Default table size
  localparam int unsigned MAX_COLUMNS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF    = 256;

  // Reset values of the grid size registers
  localparam logic [CFG_W-1:0] COLUMNS_RST = 9'd256;
  localparam logic [CFG_W-1:0] ROWS_RST    = 9'd256;

  // One in Q0.8 weight units
  localparam logic [8:0] WEIGHT_ONE = 9'd256;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_idx_e;

  // Input beat
  typedef struct packed {
    op_e                         operation;
    logic [7:0]                  cell_column;
    logic [7:0]                  cell_row;
    logic [HEIGHT_W-1:0]         cell_height;
    logic signed [COORD_W-1:0]   query_x;
    logic signed [COORD_W-1:0]   query_y;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [15:0] height_out;
    logic        in_range;
  } out_t;

  // Located item: cell, neighbours, fractions, or write request
  typedef struct packed {
    op_e                 op;
    logic                hit;
    logic [CELL_W-1:0]   gx;
    logic [CELL_W-1:0]   x1;
    logic [CELL_W-1:0]   gy;
    logic [CELL_W-1:0]   y1;
    logic [7:0]          fx;
    logic [7:0]          fy;
    logic [7:0]          wr_col;
    logic [7:0]          wr_row;
    logic [HEIGHT_W-1:0] wr_height;
    logic                wr_ok;
  } loc_t;

  // Query state carried alongside the bank read
  typedef struct packed {
    logic       hit;
    logic [7:0] fx;
    logic [7:0] fy;
    logic       gx_par;
    logic       x1_par;
    logic       gy_par;
    logic       y1_par;
  } meta_t;

endpackage

`default_nettype wire

@@ rtl/core/ths_bank.sv @@
// One parity bank of the height table: synchronous write, registered read.
// Depends on ths_pkg for the height width.
`default_nettype none

module ths_bank #(
  parameter int unsigned AW = 14
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [ths_pkg::HEIGHT_W-1:0]  wdata_i,
  output logic [ths_pkg::HEIGHT_W-1:0]  rdata_o
);
  import ths_pkg::*;

  logic [HEIGHT_W-1:0] mem_q [2**AW];
  logic [HEIGHT_W-1:0] rdata_q;

  // Single port; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/ths_locate.sv @@
// Input stage: maps a query to its grid cell, neighbours and fractions,
// or checks a write against the table size. Depends on ths_pkg.
`default_nettype none

module ths_locate #(
  parameter int unsigned MAX_COLUMNS = ths_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = ths_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ths_pkg::in_t               in_data_i,
  input  logic [ths_pkg::CFG_W-1:0]  columns_i,
  input  logic [ths_pkg::CFG_W-1:0]  rows_i,
  input  logic                       take_i,
  output logic                       loc_valid_o,
  output ths_pkg::loc_t              loc_o
);
  import ths_pkg::*;

  logic        valid_q, valid_d;
  loc_t        loc_q;
  logic        accept;

  logic [8:0]  cols, rws;
  logic [17:0] tx, ty, mag_x, mag_y;
  logic [8:0]  whole_x, whole_y;
  logic [9:0]  nx, ny;
  logic        in_x, in_y;
  loc_t        loc_d;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Grid size limited to the table size
  always_comb begin
    cols = ({4'b0, columns_i} > 13'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : columns_i;
    rws  = ({4'b0, rows_i} > 13'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows_i;
  end

  // Grid coordinates, truncated toward zero
  always_comb begin
    tx = {{2{in_data_i.query_x[15]}}, in_data_i.query_x} + {2'b0, cols[8:1], 8'h00};
    ty = {2'b0, rws[8:1], 8'h00} - {{2{in_data_i.query_y[15]}}, in_data_i.query_y};
    mag_x = tx[17] ? (~tx + 18'd1) : tx;
    mag_y = ty[17] ? (~ty + 18'd1) : ty;
    whole_x = mag_x[16:8];
    whole_y = mag_y[16:8];
    // a coordinate in (-1,0) still lands in cell 0
    in_x = !(tx[17] && (whole_x != 9'd0)) && (whole_x < cols);
    in_y = !(ty[17] && (whole_y != 9'd0)) && (whole_y < rws);
    nx = {1'b0, whole_x} + 10'd1;
    ny = {1'b0, whole_y} + 10'd1;
  end

  // Next located item
  always_comb begin
    loc_d.op        = in_data_i.operation;
    loc_d.hit       = in_x && in_y;
    loc_d.gx        = whole_x;
    loc_d.gy        = whole_y;
    // neighbours past the last column or row clamp to the edge
    loc_d.x1        = (nx < {1'b0, cols}) ? nx[8:0] : cols - 9'd1;
    loc_d.y1        = (ny < {1'b0, rws}) ? ny[8:0] : rws - 9'd1;
    loc_d.fx        = mag_x[7:0];
    loc_d.fy        = mag_y[7:0];
    loc_d.wr_col    = in_data_i.cell_column;
    loc_d.wr_row    = in_data_i.cell_row;
    loc_d.wr_height = in_data_i.cell_height;
    loc_d.wr_ok     = ({5'b0, in_data_i.cell_column} < 13'(MAX_COLUMNS)) &&
                      ({5'b0, in_data_i.cell_row} < 13'(MAX_ROWS));
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      loc_q <= loc_d;
    end
  end

  assign loc_valid_o = valid_q;
  assign loc_o       = loc_q;

endmodule

`default_nettype wire

@@ rtl/core/ths_blend.sv @@
// Triangle blend: weight products in one stage, sum into the output register.
// Depends on ths_pkg for meta_t, out_t and widths.
`default_nettype none

module ths_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  ths_pkg::meta_t                     meta_i,
  input  logic [3:0][ths_pkg::HEIGHT_W-1:0]  rdata_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ths_pkg::out_t                      out_data_o
);
  import ths_pkg::*;

  logic                c_valid_q, c_valid_d;
  logic                c_hit_q;
  logic [PROD_W-1:0]   c_prod_q [3];
  logic                out_valid_q, out_valid_d;
  out_t                out_data_q;

  logic                out_free, c_load, out_load;
  logic [8:0]          fsum;
  logic                upper;
  logic [8:0]          w0, w1, w2;
  logic [HEIGHT_W-1:0] h00, h10, h01, h11, ha;
  logic [17:0]         total;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ready_o  = !c_valid_q || out_free;
  assign c_load   = valid_i && ready_o;
  assign out_load = c_valid_q && out_free;

  // Corner heights by bank parity
  always_comb begin
    h00 = rdata_i[{meta_i.gx_par, meta_i.gy_par}];
    h10 = rdata_i[{meta_i.x1_par, meta_i.gy_par}];
    h01 = rdata_i[{meta_i.gx_par, meta_i.y1_par}];
    h11 = rdata_i[{meta_i.x1_par, meta_i.y1_par}];
  end

  // Triangle choice and weights (sum to one)
  always_comb begin
    fsum  = {1'b0, meta_i.fx} + {1'b0, meta_i.fy};
    upper = fsum > WEIGHT_ONE;
    w0    = upper ? (fsum - WEIGHT_ONE) : (WEIGHT_ONE - fsum);
    ha    = upper ? h11 : h00;
    w1    = upper ? (WEIGHT_ONE - {1'b0, meta_i.fy}) : {1'b0, meta_i.fx};
    w2    = upper ? (WEIGHT_ONE - {1'b0, meta_i.fx}) : {1'b0, meta_i.fy};
  end

  always_ff @(posedge clk_i) begin
    if (c_load) begin
      c_hit_q     <= meta_i.hit;
      c_prod_q[0] <= {8'b0, w0} * {9'b0, ha};
      c_prod_q[1] <= {8'b0, w1} * {9'b0, h10};
      c_prod_q[2] <= {8'b0, w2} * {9'b0, h01};
    end
  end

  assign total = {1'b0, c_prod_q[0]} + {1'b0, c_prod_q[1]} + {1'b0, c_prod_q[2]};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.height_out <= c_hit_q ? total[15:0] : 16'd0;
      out_data_q.in_range   <= c_hit_q;
    end
  end

  // Stage valids
  always_comb begin
    c_valid_d = c_valid_q;
    if (c_load) begin
      c_valid_d = 1'b1;
    end else if (out_free) begin
      c_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      c_valid_q   <= c_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/core/terrain_height_sampler.sv @@
// Terrain height sampler top level: grid size registers, four parity banks,
// read stage and pipeline control. Depends on ths_pkg, ths_locate,
// ths_bank and ths_blend.
//
//   port group   direction  handshake               payload
//   in           input      in_valid_i/in_stall_o   in_data_i  (ths_pkg::in_t)
//   out          output     out_valid_o/out_stall_i out_data_o (ths_pkg::out_t)
//   cfg          input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while the output is not stalled. A query result
// passes the locate, bank read, products and output registers in that order.
// The table is split in four banks by column and row parity, so the four
// corners of a cell come out of one read in the same cycle.
// Writes update the banks as they leave the locate stage; later queries see them.
// Reset clears only the pipeline valids and the grid size; the table holds
// no defined data until written. A stall at the output backs up stage by stage.
`default_nettype none

module terrain_height_sampler #(
  parameter int unsigned MAX_COLUMNS = ths_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = ths_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ths_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ths_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  ths_pkg::cfg_idx_e          cfg_idx_i,
  input  logic [ths_pkg::CFG_W-1:0]  cfg_data_i
);
  import ths_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned BCW = (MAX_COLUMNS > 2) ? $clog2((MAX_COLUMNS + 1) / 2) : 1;
  localparam int unsigned BRW = (MAX_ROWS > 2) ? $clog2((MAX_ROWS + 1) / 2) : 1;
  localparam int unsigned AW  = BCW + BRW;

  logic [CFG_W-1:0] columns_q, rows_q;

  logic                   loc_valid;
  loc_t                   loc;
  logic                   a_adv;
  logic                   b_valid_q, b_valid_d;
  meta_t                  b_meta_q;
  logic                   b_free;
  logic                   blend_ready;
  logic                   is_query;
  logic [3:0][HEIGHT_W-1:0] bank_rdata;

  // Grid size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RST;
      rows_q    <= ROWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLUMNS: columns_q <= cfg_data_i;
        CFG_ROWS:    rows_q    <= cfg_data_i;
        default:     columns_q <= columns_q;
      endcase
    end
  end

  ths_locate #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_locate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .columns_i   (columns_q),
    .rows_i      (rows_q),
    .take_i      (b_free),
    .loc_valid_o (loc_valid),
    .loc_o       (loc)
  );

  assign b_free   = !b_valid_q || blend_ready;
  assign a_adv    = loc_valid && b_free;
  assign is_query = (loc.op == OP_QUERY);

  // Bank ports: each bank takes the column and row of its own parity
  for (genvar pc = 0; pc < 2; pc++) begin : g_col
    for (genvar pr = 0; pr < 2; pr++) begin : g_row
      logic [CELL_W-1:0] col, row;
      logic [CW-1:0]     col_n;
      logic [RW-1:0]     row_n;
      logic [AW-1:0]     addr;
      logic              we, re;

      always_comb begin
        if (is_query) begin
          col = (loc.gx[0] == 1'(pc)) ? loc.gx : loc.x1;
          row = (loc.gy[0] == 1'(pr)) ? loc.gy : loc.y1;
        end else begin
          col = {1'b0, loc.wr_col};
          row = {1'b0, loc.wr_row};
        end
        col_n = CW'(col);
        row_n = RW'(row);
        addr  = {BCW'(col_n >> 1), BRW'(row_n >> 1)};
        we    = a_adv && !is_query && loc.wr_ok &&
                (loc.wr_col[0] == 1'(pc)) && (loc.wr_row[0] == 1'(pr));
        re    = a_adv && is_query;
      end

      ths_bank #(
        .AW (AW)
      ) u_bank (
        .clk_i   (clk_i),
        .we_i    (we),
        .re_i    (re),
        .addr_i  (addr),
        .wdata_i (loc.wr_height),
        .rdata_o (bank_rdata[pc * 2 + pr])
      );
    end
  end

  // Read stage: query state waits beside the bank read data
  always_comb begin
    b_valid_d = b_valid_q;
    if (a_adv && is_query) begin
      b_valid_d = 1'b1;
    end else if (blend_ready) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && is_query) begin
      b_meta_q.hit    <= loc.hit;
      b_meta_q.fx     <= loc.fx;
      b_meta_q.fy     <= loc.fy;
      b_meta_q.gx_par <= loc.gx[0];
      b_meta_q.x1_par <= loc.x1[0];
      b_meta_q.gy_par <= loc.gy[0];
      b_meta_q.y1_par <= loc.y1[0];
    end
  end

  ths_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (b_valid_q),
    .ready_o     (blend_ready),
    .meta_i      (b_meta_q),
    .rdata_i     (bank_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/terrain_height_sampler_tb.sv @@
// Self-checking testbench for terrain_height_sampler: fills height cells, steps
// through several grid sizes and checks every query beat against a local model.
// Depends on ths_pkg and the terrain_height_sampler RTL.

module terrain_height_sampler_tb;
  import ths_pkg::*;

  localparam int GRID_MAX    = 256;   // table side, matches the DUT default
  localparam int UNIT        = 256;   // one in Q0.8 weight units
  localparam int N_PHASES    = 9;
  localparam int PHASE_BEATS = 58;
  localparam int HOLD_LEN    = 48;
  localparam int GAP_CAP     = 40;
  localparam int SHOW_MAX    = 10;
  localparam int TAIL_CYCLES = 10;

  // Per-phase grid size (-1 picks a random size) and idle percentages
  localparam int PH_COLS  [N_PHASES] = '{256, 2, 0, 511, 256, 17, 1, 300, -1};
  localparam int PH_ROWS  [N_PHASES] = '{256, 2, 256, 300, 256, 256, 1, 0, -1};
  localparam int PH_SEND  [N_PHASES] = '{0, 82, 0, 38, 0, 82, 0, 38, 0};
  localparam int PH_STALL [N_PHASES] = '{0, 0, 82, 38, 0, 0, 82, 38, 0};
  localparam bit PH_HOLD  [N_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0};

  typedef struct {
    int gx;
    int gy;
    int x1;
    int y1;
    int fx;
    int fy;
    bit hit;
  } cell_pos_t;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t want;
  } step_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_t              in_data   = '0;
  logic             out_stall = 1'b0;
  logic             cfg_we    = 1'b0;
  cfg_idx_e         cfg_idx   = CFG_COLUMNS;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_stall;
  logic             out_valid;
  out_t             out_data;

  // Model state: heights by {column,row}, grid size as last written
  logic [7:0]       height_map [GRID_MAX*GRID_MAX];
  bit               cell_known [GRID_MAX*GRID_MAX];
  logic [CFG_W-1:0] grid_cols = COLUMNS_RST;
  logic [CFG_W-1:0] grid_rows = ROWS_RST;
  out_t             expected_heights [$];

  int   mismatches    = 0;
  int   beats_sent    = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  bit   hold_req      = 1'b0;
  int   hold_cnt      = 0;
  bit   typed_on      = 1'b0;
  out_t typed_out     = '0;

  terrain_height_sampler DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // Sizes above the table act as the table size
  function automatic int clip_size(int n);
    return (n > GRID_MAX) ? GRID_MAX : n;
  endfunction

  // Truncate toward zero; fraction is the low byte of the magnitude
  function automatic void split_axis(input int t, output int whole, output int frac);
    int mag;
    mag = (t < 0) ? -t : t;
    whole = (t < 0) ? -(mag >> 8) : (mag >> 8);
    frac = mag & 8'hFF;
  endfunction

  // World Q8.8 position to cell, clamped neighbours and fractions
  function automatic cell_pos_t locate_cell(logic signed [15:0] qx, logic signed [15:0] qy);
    cell_pos_t p;
    int cols, rws, tx, ty;
    cols = clip_size(int'(grid_cols));
    rws  = clip_size(int'(grid_rows));
    tx = int'(qx) + ((cols / 2) << 8);
    ty = ((rws / 2) << 8) - int'(qy);
    split_axis(tx, p.gx, p.fx);
    split_axis(ty, p.gy, p.fy);
    p.hit = (p.gx >= 0) && (p.gy >= 0) && (p.gx < cols) && (p.gy < rws);
    p.x1 = (p.gx + 1 < cols) ? p.gx + 1 : cols - 1;
    p.y1 = (p.gy + 1 < rws) ? p.gy + 1 : rws - 1;
    return p;
  endfunction

  // Barycentric blend over the lower-left or upper-right triangle
  function automatic out_t sample_height(in_t b);
    cell_pos_t p;
    out_t r;
    int h00, h10, h01, h11, h;
    p = locate_cell(b.query_x, b.query_y);
    r = '0;
    if (p.hit) begin
      h00 = height_map[p.gx * GRID_MAX + p.gy];
      h10 = height_map[p.x1 * GRID_MAX + p.gy];
      h01 = height_map[p.gx * GRID_MAX + p.y1];
      h11 = height_map[p.x1 * GRID_MAX + p.y1];
      if (p.fx + p.fy <= UNIT) begin
        h = (UNIT - p.fx - p.fy) * h00 + p.fx * h10 + p.fy * h01;
      end else begin
        h = (UNIT - p.fy) * h10 + (p.fx + p.fy - UNIT) * h11 + (UNIT - p.fx) * h01;
      end
      r.height_out = h[15:0];
      r.in_range   = 1'b1;
    end
    return r;
  endfunction

  function automatic in_t make_write(logic [7:0] col, logic [7:0] row, logic [7:0] hgt);
    in_t b;
    b.operation   = OP_WRITE;
    b.cell_column = col;
    b.cell_row    = row;
    b.cell_height = hgt;
    b.query_x     = 16'($urandom);
    b.query_y     = 16'($urandom);
    return b;
  endfunction

  function automatic in_t make_query(logic [15:0] qx, logic [15:0] qy);
    in_t b;
    b.operation   = OP_QUERY;
    b.cell_column = 8'($urandom);
    b.cell_row    = 8'($urandom);
    b.cell_height = 8'($urandom);
    b.query_x     = qx;
    b.query_y     = qy;
    return b;
  endfunction

  // Coordinate aimed at cells -2 .. span+1 on one axis, sometimes fully random
  function automatic logic [15:0] aim_axis(int span, int offset, bit flip);
    int t, v;
    t = int'($urandom_range(0, (span + 4) * 256 - 1)) - 512;
    v = flip ? offset - t : t - offset;
    if ($urandom_range(3) == 0 || v < -32768 || v > 32767) return 16'($urandom);
    return v[15:0];
  endfunction

  task automatic report_miss(input string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("%s", msg);
  endtask

  // Offer one input beat after a random gap; returns at the next falling edge
  task automatic push_beat(input in_t b);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_cell(input logic [7:0] col, input logic [7:0] row, input logic [7:0] hgt);
    push_beat(make_write(col, row, hgt));
    cell_known[{col, row}] = 1'b1;
  endtask

  // Random query; any corner it reads gets written first
  task automatic probe_random();
    in_t b;
    cell_pos_t p;
    int cols, rws;
    int cx [4];
    int cy [4];
    cols = clip_size(int'(grid_cols));
    rws  = clip_size(int'(grid_rows));
    b = make_query(aim_axis(cols, (cols / 2) << 8, 1'b0), aim_axis(rws, (rws / 2) << 8, 1'b1));
    p = locate_cell(b.query_x, b.query_y);
    if (p.hit) begin
      cx = '{p.gx, p.x1, p.gx, p.x1};
      cy = '{p.gy, p.gy, p.y1, p.y1};
      for (int k = 0; k < 4; k++) begin
        if (!cell_known[cx[k] * GRID_MAX + cy[k]]) begin
          write_cell(8'(cx[k]), 8'(cy[k]), 8'($urandom));
        end
      end
    end
    push_beat(b);
  endtask

  // Wait out every pending result plus the write path
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_heights.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_grid(input int cols, input int rws);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_COLUMNS;
    cfg_data <= cols[CFG_W-1:0];
    @(negedge clk);
    cfg_idx  <= CFG_ROWS;
    cfg_data <= rws[CFG_W-1:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
    grid_cols = cols[CFG_W-1:0];
    grid_rows = rws[CFG_W-1:0];
  endtask

  // Receiver: random stalls, plus one long counted hold when requested
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt++;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!hold_req) hold_cnt = 0;
    end
  end

  // Scoreboard: check result beats, predict on accepted input beats
  always @(posedge clk) begin : watch
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_heights.size() == 0) begin
          report_miss($sformatf("unexpected result: height_out=%h in_range=%b",
                                out_data.height_out, out_data.in_range));
        end else begin
          want = expected_heights.pop_front();
          if (want.height_out !== out_data.height_out || want.in_range !== out_data.in_range) begin
            report_miss($sformatf("mismatch: expected height_out=%h in_range=%b, got %h %b",
                                  want.height_out, want.in_range,
                                  out_data.height_out, out_data.in_range));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_WRITE) begin
          height_map[{in_data.cell_column, in_data.cell_row}] = in_data.cell_height;
        end else begin
          // append the predicted beat at the tail
          want = typed_on ? typed_out : sample_height(in_data);
          expected_heights = {expected_heights, want};
        end
      end
    end
  end

  initial begin : stimulus
    step_t script [$];
    int cols, rws, stop_at;
    // Directed beats at the reset grid of 256 x 256
    script = '{
      '{make_write(8'd128, 8'd128, 8'hAB), 1'b0, '0},
      '{make_write(8'd129, 8'd128, 8'h10), 1'b0, '0},
      '{make_write(8'd128, 8'd129, 8'h20), 1'b0, '0},
      '{make_write(8'd129, 8'd129, 8'hFF), 1'b0, '0},
      // grid center, no fraction: plain h00
      '{make_query(16'h0000, 16'h0000), 1'b1, '{16'hAB00, 1'b1}},
      '{make_query(16'h0080, 16'h0000), 1'b0, '0},
      // fractions summing to one (lower) and just above (upper)
      '{make_query(16'h0080, 16'hFF80), 1'b0, '0},
      '{make_query(16'h0081, 16'hFF80), 1'b0, '0},
      '{make_query(16'h00FF, 16'hFF01), 1'b0, '0},
      // most negative y lands one row past the grid
      '{make_query(16'h0000, 16'h8000), 1'b1, '{16'h0000, 1'b0}},
      // last column: right neighbour clamps to the edge
      '{make_write(8'd255, 8'd0, 8'hFF), 1'b0, '0},
      '{make_write(8'd255, 8'd1, 8'h00), 1'b0, '0},
      '{make_query(16'h7FFF, 16'h7FFF), 1'b0, '0},
      '{make_write(8'd0, 8'd0, 8'h00), 1'b0, '0},
      '{make_write(8'd1, 8'd0, 8'hFF), 1'b0, '0},
      '{make_write(8'd0, 8'd1, 8'h55), 1'b0, '0},
      '{make_write(8'd1, 8'd1, 8'hAA), 1'b0, '0},
      '{make_query(16'h8000, 16'h7FFF), 1'b0, '0},
      '{make_query(16'h80FF, 16'h7F01), 1'b0, '0}
    };
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        cols = PH_COLS[ph];
        rws  = PH_ROWS[ph];
        if (cols < 0) begin
          cols = $urandom_range(0, 511);
          rws  = $urandom_range(0, 511);
        end
        set_grid(cols, rws);
      end
      send_idle_pct = PH_SEND[ph];
      stall_pct     = PH_STALL[ph];
      hold_req      = PH_HOLD[ph];
      if (ph == 0) begin
        foreach (script[i]) begin
          typed_on  = script[i].typed;
          typed_out = script[i].want;
          push_beat(script[i].beat);
        end
        typed_on = 1'b0;
      end
      // Random beats: mostly queries over written cells, some stray writes
      stop_at = beats_sent + PHASE_BEATS;
      while (beats_sent < stop_at) begin
        if ($urandom_range(99) < 65) begin
          probe_random();
        end else begin
          write_cell(8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      drain();
      hold_req = 1'b0;
    end
    if (mismatches == 0) begin
      $display("terrain_height_sampler_tb: PASS");
    end else begin
      $display("terrain_height_sampler_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #400000;
    $display("terrain_height_sampler_tb: FAIL");
    $finish;
  end

endmodule
